/* sv/q4ep_pkg.sv */
// Shared types, widths and codes for the Q4 edge pressure nodal load pipeline.
package q4ep_pkg;

    // Width of every Q16.16 field on the streams.
    localparam int FIELD_W = 32;

    // Number of corner nodes of the element.
    localparam int NODES = 4;

    // Stream payload widths.
    localparam int S_TDATA_W = 320;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 256;
    localparam int M_TUSER_W = 3;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_THICK_BAD  = 3'd1;
    localparam logic [2:0] ST_AREA_BAD   = 3'd2;
    localparam logic [2:0] ST_EDGE_BAD   = 3'd3;
    localparam logic [2:0] ST_ZERO_EDGE  = 3'd4;

    typedef logic [1:0] node_idx_t;

    // Start and end node of each edge, walking counterclockwise.
    localparam node_idx_t EDGE_ENDS [NODES][2] = '{
        '{2'd0, 2'd1},
        '{2'd1, 2'd2},
        '{2'd2, 2'd3},
        '{2'd3, 2'd0}
    };

    // Check results that travel down the pipeline with each item.
    typedef struct packed {
        logic      thick_bad;
        logic      area_bad;
        logic      edge_bad;
        logic      zero_len;
        node_idx_t edge_idx;
    } chk_t;

endpackage

/* sv/q4ep_diff.sv */
// First stage: coordinate differences, edge vector selection and input checks.
module q4ep_diff #(
    parameter int CW = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [q4ep_pkg::NODES-1:0][CW-1:0]    node_x,
    input  logic [q4ep_pkg::NODES-1:0][CW-1:0]    node_y,
    input  logic [2:0]                            edge_select,
    input  logic [q4ep_pkg::FIELD_W-1:0]          pressure,
    input  logic [q4ep_pkg::FIELD_W-1:0]          thickness,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [CW:0]                    d02x,
    output logic signed [CW:0]                    d13y,
    output logic signed [CW:0]                    d13x,
    output logic signed [CW:0]                    d20y,
    output logic signed [CW:0]                    edge_dx,
    output logic signed [CW:0]                    edge_dy,
    output logic [q4ep_pkg::FIELD_W-1:0]          pressure_out,
    output logic [q4ep_pkg::FIELD_W-1:0]          thickness_out,
    output q4ep_pkg::chk_t                        chk
);
    import q4ep_pkg::*;

    localparam int DW = CW + 1;

    logic                      valid_reg;
    logic                      adv;
    logic signed [DW-1:0]      xs [NODES];
    logic signed [DW-1:0]      ys [NODES];
    node_idx_t                 end_a;
    node_idx_t                 end_b;
    chk_t                      chk_next;

    logic signed [DW-1:0]      d02x_reg, d13y_reg, d13x_reg, d20y_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg;
    logic [FIELD_W-1:0]        pressure_reg, thickness_reg;
    chk_t                      chk_reg;

    // Sign-extend the used coordinate bits by one guard bit.
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            xs[i] = {node_x[i][CW-1], node_x[i]};
            ys[i] = {node_y[i][CW-1], node_y[i]};
        end
    end

    // Pick the end nodes of the loaded edge and flag the simple checks.
    always_comb begin
        end_a              = EDGE_ENDS[edge_select[1:0]][0];
        end_b              = EDGE_ENDS[edge_select[1:0]][1];
        chk_next           = '0;
        chk_next.thick_bad = thickness[FIELD_W-1] | (thickness == '0);
        chk_next.edge_bad  = edge_select[2];
        chk_next.edge_idx  = edge_select[1:0];
    end

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // Stage valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            d02x_reg      <= xs[2] - xs[0];
            d13y_reg      <= ys[3] - ys[1];
            d13x_reg      <= xs[3] - xs[1];
            d20y_reg      <= ys[2] - ys[0];
            dx_reg        <= xs[end_b] - xs[end_a];
            dy_reg        <= ys[end_b] - ys[end_a];
            pressure_reg  <= pressure;
            thickness_reg <= thickness;
            chk_reg       <= chk_next;
        end
    end

    assign out_valid     = valid_reg;
    assign d02x          = d02x_reg;
    assign d13y          = d13y_reg;
    assign d13x          = d13x_reg;
    assign d20y          = d20y_reg;
    assign edge_dx       = dx_reg;
    assign edge_dy       = dy_reg;
    assign pressure_out  = pressure_reg;
    assign thickness_out = thickness_reg;
    assign chk           = chk_reg;

endmodule

/* sv/q4ep_mult.sv */
// Second and third stages: area products, p*t, then split force partial products.
module q4ep_mult #(
    parameter int DW = 33
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DW-1:0]              d02x,
    input  logic signed [DW-1:0]              d13y,
    input  logic signed [DW-1:0]              d13x,
    input  logic signed [DW-1:0]              d20y,
    input  logic signed [DW-1:0]              edge_dx,
    input  logic signed [DW-1:0]              edge_dy,
    input  logic [q4ep_pkg::FIELD_W-1:0]      pressure,
    input  logic [q4ep_pkg::FIELD_W-1:0]      thickness,
    input  q4ep_pkg::chk_t                    chk_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DW+32:0]             fx_lo,
    output logic signed [DW+31:0]             fx_hi,
    output logic signed [DW+32:0]             fy_lo,
    output logic signed [DW+31:0]             fy_hi,
    output q4ep_pkg::chk_t                    chk_out
);
    import q4ep_pkg::*;

    localparam int AW  = 2 * DW;
    localparam int PTW = 2 * FIELD_W;
    localparam int LW  = DW + FIELD_W + 1;
    localparam int HW  = DW + FIELD_W;

    logic                     va_reg, vb_reg;
    logic                     adv_a, adv_b;
    logic signed [AW-1:0]     area_p_reg, area_n_reg;
    logic signed [PTW-1:0]    pt_reg;
    logic signed [DW-1:0]     fdx_reg, fdy_reg;
    chk_t                     chk_a_reg, chk_b_reg;
    logic signed [LW-1:0]     fx_lo_reg, fy_lo_reg;
    logic signed [HW-1:0]     fx_hi_reg, fy_hi_reg;
    chk_t                     chk_a_next;
    chk_t                     chk_b_next;

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    // The zero-length test is taken on the selected edge vector.
    always_comb begin
        chk_a_next          = chk_in;
        chk_a_next.zero_len = (edge_dx == '0) && (edge_dy == '0);
    end

    // The area is positive only when the first cross product is the larger.
    always_comb begin
        chk_b_next          = chk_a_reg;
        chk_b_next.area_bad = !(area_p_reg > area_n_reg);
    end

    // Valid bits of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (adv_a) begin
                va_reg <= in_valid;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    // Stage A: the two cross products of the shoelace area and p*t.
    always_ff @(posedge aclk) begin
        if (adv_a && in_valid) begin
            area_p_reg <= d02x * d13y;
            area_n_reg <= d13x * d20y;
            pt_reg     <= $signed(pressure) * $signed(thickness);
            fdx_reg    <= -edge_dy;
            fdy_reg    <= edge_dx;
            chk_a_reg  <= chk_a_next;
        end
    end

    // Stage B: area sign and the force products, with p*t split in halves.
    always_ff @(posedge aclk) begin
        if (adv_b && va_reg) begin
            fx_lo_reg <= $signed({1'b0, pt_reg[FIELD_W-1:0]}) * fdx_reg;
            fx_hi_reg <= $signed(pt_reg[PTW-1:FIELD_W]) * fdx_reg;
            fy_lo_reg <= $signed({1'b0, pt_reg[FIELD_W-1:0]}) * fdy_reg;
            fy_hi_reg <= $signed(pt_reg[PTW-1:FIELD_W]) * fdy_reg;
            chk_b_reg <= chk_b_next;
        end
    end

    assign out_valid = vb_reg;
    assign fx_lo     = fx_lo_reg;
    assign fx_hi     = fx_hi_reg;
    assign fy_lo     = fy_lo_reg;
    assign fy_hi     = fy_hi_reg;
    assign chk_out   = chk_b_reg;

endmodule

/* sv/q4ep_out.sv */
// Last stage: force sums, floor scaling, saturation, status and output register.
module q4ep_out #(
    parameter int DW = 33
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [DW+32:0]                fx_lo,
    input  logic signed [DW+31:0]                fx_hi,
    input  logic signed [DW+32:0]                fy_lo,
    input  logic signed [DW+31:0]                fy_hi,
    input  q4ep_pkg::chk_t                       chk,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [q4ep_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [q4ep_pkg::M_TUSER_W-1:0]       m_tuser
);
    import q4ep_pkg::*;

    localparam int SW    = DW + 2 * FIELD_W + 1;
    localparam int SHIFT = FIELD_W + 1;
    localparam int QW    = SW - SHIFT;
    localparam logic signed [QW-1:0] Q_MAX = {{(QW - FIELD_W){1'b0}}, 1'b0, {(FIELD_W - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {{(QW - FIELD_W){1'b1}}, 1'b1, {(FIELD_W - 1){1'b0}}};

    // Joins the halves, divides by 2^33 rounding down and clamps to 32 bits.
    function automatic logic [FIELD_W-1:0] scale_sat(
        input logic signed [DW+32:0] lo,
        input logic signed [DW+31:0] hi
    );
        logic signed [SW-1:0] sum;
        logic signed [QW-1:0] q;
        logic [FIELD_W-1:0]   r;
        sum = (SW'(hi) <<< FIELD_W) + SW'(lo);
        q   = $signed(sum[SW-1:SHIFT]);
        if (q > Q_MAX) begin
            r = Q_MAX[FIELD_W-1:0];
        end else if (q < Q_MIN) begin
            r = Q_MIN[FIELD_W-1:0];
        end else begin
            r = q[FIELD_W-1:0];
        end
        return r;
    endfunction

    logic                          valid_reg;
    logic                          adv;
    logic [FIELD_W-1:0]            fx, fy;
    logic [2:0]                    status_next;
    node_idx_t                     end_a, end_b;
    logic [2*NODES-1:0][FIELD_W-1:0] loads_next;
    logic [M_TDATA_W-1:0]          tdata_reg;
    logic [M_TUSER_W-1:0]          tuser_reg;

    // Status follows the order of the checks; only the first failure counts.
    always_comb begin
        if (chk.thick_bad) begin
            status_next = ST_THICK_BAD;
        end else if (chk.area_bad) begin
            status_next = ST_AREA_BAD;
        end else if (chk.edge_bad) begin
            status_next = ST_EDGE_BAD;
        end else if (chk.zero_len) begin
            status_next = ST_ZERO_EDGE;
        end else begin
            status_next = ST_OK;
        end
    end

    // With an OK status both end nodes of the edge carry the same force; all else is zero.
    always_comb begin
        fx         = scale_sat(fx_lo, fx_hi);
        fy         = scale_sat(fy_lo, fy_hi);
        end_a      = EDGE_ENDS[chk.edge_idx][0];
        end_b      = EDGE_ENDS[chk.edge_idx][1];
        loads_next = '0;
        if (status_next == ST_OK) begin
            loads_next[{end_a, 1'b0}] = fx;
            loads_next[{end_a, 1'b1}] = fy;
            loads_next[{end_b, 1'b0}] = fx;
            loads_next[{end_b, 1'b1}] = fy;
        end
    end

    assign adv      = !valid_reg || m_tready;
    assign in_ready = adv;

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            tdata_reg <= loads_next;
            tuser_reg <= status_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

/* sv/q4_edge_pressure_nodal_load_top.sv */
// Top level of the Q4 consistent edge pressure nodal load pipeline.
//
//  Channel   Direction  tdata (lowest bits first)                    tuser
//  s_        in         node0_x..node3_y, pressure, thickness        edge_select
//  m_        out        load0_x..load3_y                             status
//
// One item can enter in every cycle unless m_tready stalls. The depth of the
// registered pipeline is set by the chain of multiplications:
// differences, area products and p*t, split force products, then the sum.
// aresetn is synchronous and active low and clears every stage valid bit.
// A stalled m_tready holds the output and fills bubbles behind it before
// s_tready falls; no item is lost or repeated.
module q4_edge_pressure_nodal_load_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y, node3_x, node3_y,
    // pressure, thickness (32 bits each)
    input  logic [q4ep_pkg::S_TDATA_W-1:0]      s_tdata,
    // edge_select
    input  logic [q4ep_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // load0_x, load0_y, load1_x, load1_y, load2_x, load2_y, load3_x, load3_y
    output logic [q4ep_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [q4ep_pkg::M_TUSER_W-1:0]      m_tuser
);
    import q4ep_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int DW = CW + 1;

    logic [NODES-1:0][CW-1:0]  node_x, node_y;
    logic [FIELD_W-1:0]        pressure, thickness;

    logic                      d_valid, d_ready;
    logic signed [DW-1:0]      d02x, d13y, d13x, d20y, edge_dx, edge_dy;
    logic [FIELD_W-1:0]        d_pressure, d_thickness;
    chk_t                      d_chk;

    logic                      p_valid, p_ready;
    logic signed [DW+32:0]     fx_lo, fy_lo;
    logic signed [DW+31:0]     fx_hi, fy_hi;
    chk_t                      p_chk;

    // Unpack the corner coordinates; only the low CW bits of each are used.
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            node_x[i] = s_tdata[2 * FIELD_W * i +: CW];
            node_y[i] = s_tdata[2 * FIELD_W * i + FIELD_W +: CW];
        end
    end

    assign pressure  = s_tdata[2 * NODES * FIELD_W +: FIELD_W];
    assign thickness = s_tdata[(2 * NODES + 1) * FIELD_W +: FIELD_W];

    q4ep_diff #(
        .CW (CW)
    ) u_diff (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .node_x        (node_x),
        .node_y        (node_y),
        .edge_select   (s_tuser),
        .pressure      (pressure),
        .thickness     (thickness),
        .out_valid     (d_valid),
        .out_ready     (d_ready),
        .d02x          (d02x),
        .d13y          (d13y),
        .d13x          (d13x),
        .d20y          (d20y),
        .edge_dx       (edge_dx),
        .edge_dy       (edge_dy),
        .pressure_out  (d_pressure),
        .thickness_out (d_thickness),
        .chk           (d_chk)
    );

    q4ep_mult #(
        .DW (DW)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .d02x      (d02x),
        .d13y      (d13y),
        .d13x      (d13x),
        .d20y      (d20y),
        .edge_dx   (edge_dx),
        .edge_dy   (edge_dy),
        .pressure  (d_pressure),
        .thickness (d_thickness),
        .chk_in    (d_chk),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .fx_lo     (fx_lo),
        .fx_hi     (fx_hi),
        .fy_lo     (fy_lo),
        .fy_hi     (fy_hi),
        .chk_out   (p_chk)
    );

    q4ep_out #(
        .DW (DW)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p_valid),
        .in_ready (p_ready),
        .fx_lo    (fx_lo),
        .fx_hi    (fx_hi),
        .fy_lo    (fy_lo),
        .fy_hi    (fy_hi),
        .chk      (p_chk),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/q4ep_checker.sv */
// Port-level checker for the Q4 edge pressure nodal load top level, with its bind.
module q4ep_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [q4ep_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [q4ep_pkg::M_TUSER_W-1:0]     m_tuser
);
    import q4ep_pkg::*;

    // A reset cycle leaves no result on the output.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result shown straight after reset");

    // An empty pipeline after reset takes an item at once.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready straight after reset");

    // A failed check must give all-zero loads.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("nonzero load with an error status");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_THICK_BAD) ||
                     (m_tuser == ST_AREA_BAD) || (m_tuser == ST_EDGE_BAD) ||
                     (m_tuser == ST_ZERO_EDGE))
        else $error("undefined status code");

    // A stalled result stays in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind q4_edge_pressure_nodal_load_top q4ep_checker u_q4ep_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
